### rtl/peak_envelope_ratio_limiter_macros.svh
// Assertion macros shared by the envelope limiter RTL.
`ifndef PEAK_ENVELOPE_RATIO_LIMITER_MACROS_SVH
`define PEAK_ENVELOPE_RATIO_LIMITER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PEL_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PEL_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/pel_pkg.sv
// Constants and register indexes for the peak envelope ratio limiter.
package pel_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned LevelW  = 15;
  localparam int unsigned RatioW  = 16;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ProdW   = 32;
  localparam int unsigned DvdW    = 2 * LevelW;
  localparam int unsigned CntW    = 5;

  localparam logic [LevelW-1:0] UnityQ15       = 15'd32767;
  localparam logic [LevelW-1:0] ThresholdReset = 15'd29491;
  localparam logic [RatioW-1:0] RatioReset     = 16'd1000;
  localparam logic [LevelW-1:0] AttackReset    = 15'd676;
  localparam logic [LevelW-1:0] ReleaseReset   = 15'd7;

  // Number of quotient bits produced by each of the two divisions.
  localparam logic [CntW-1:0] DivAlphaSteps = 5'd30;
  localparam logic [CntW-1:0] DivGainSteps  = 5'd15;

  typedef enum logic [CfgIdxW-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_RATIO     = 2'd1,
    REG_ATTACK    = 2'd2,
    REG_RELEASE   = 2'd3
  } cfg_reg_t;

endpackage

### rtl/peak_envelope_ratio_limiter.sv
// Peak envelope follower with fixed-ratio gain computer and output scaling.
// A new request is accepted only in the idle state, once the previous one has
// reached the output register. Above the threshold, the gain is computed by the
// one-bit-per-cycle shared restoring divider (30 steps for the threshold over
// envelope ratio, 15 for the headroom over ratio term).
// Reset (synchronous, rst_n low) clears the envelope and loads default registers.
`include "peak_envelope_ratio_limiter_macros.svh"

module peak_envelope_ratio_limiter (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write port.
  input  logic                                cfg_wr_en,
  input  logic [pel_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [pel_pkg::CfgW-1:0]            cfg_wdata,
  // Request channel.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [pel_pkg::SampleW-1:0]  in_sample_in,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pel_pkg::SampleW-1:0]  out_sample_out,
  output logic [pel_pkg::LevelW-1:0]          out_gain_applied,
  output logic [pel_pkg::LevelW-1:0]          out_envelope_level
);

  // The sequencer walks one request through the shared multiplier and the
  // shared divider step. Each state is one-hot so decoding stays trivial.
  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_ENV_MUL = 7'b0000010,
    S_ENV_UPD = 7'b0000100,
    S_DIV_A   = 7'b0001000,
    S_DIV_G   = 7'b0010000,
    S_OUT_MUL = 7'b0100000,
    S_FINISH  = 7'b1000000
  } state_t;

  localparam int unsigned LW = pel_pkg::LevelW;
  localparam int unsigned SW = pel_pkg::SampleW;
  localparam int unsigned DW = pel_pkg::DvdW;

  state_t                  state_r, state_nxt;

  // Configuration registers.
  logic [LW-1:0]                 thr_r, thr_nxt;
  logic [pel_pkg::RatioW-1:0]    ratio_r, ratio_nxt;
  logic [LW-1:0]                 atk_r, atk_nxt;
  logic [LW-1:0]                 rel_r, rel_nxt;

  // Envelope state.
  logic [LW-1:0]                 env_r, env_nxt;

  // Per-request working registers.
  logic signed [SW-1:0]          x_r, x_nxt;
  logic [LW-1:0]                 mag_r, mag_nxt;
  logic                          rise_r, rise_nxt;
  logic signed [pel_pkg::ProdW-1:0] prod_r, prod_nxt;
  logic [LW-1:0]                 a_r, a_nxt;
  logic [LW-1:0]                 gain_r, gain_nxt;

  // Shared divider registers: partial remainder, dividend/quotient shift
  // register, divisor and step counter.
  logic [pel_pkg::RatioW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]                 dvd_r, dvd_nxt;
  logic [pel_pkg::RatioW-1:0]    dvs_r, dvs_nxt;
  logic [pel_pkg::CntW-1:0]      cnt_r, cnt_nxt;

  // Output register, which lets a new request start while a result waits.
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SW-1:0]          out_sample_r, out_sample_nxt;
  logic [LW-1:0]                 out_gain_r, out_gain_nxt;
  logic [LW-1:0]                 out_env_r, out_env_nxt;

  // Combinational helpers.
  logic                          in_fire;
  logic [LW-1:0]                 in_mag;
  logic [SW-1:0]                 in_neg;
  logic                          rise;
  logic [LW-1:0]                 env_diff;
  logic [LW-1:0]                 coeff;
  logic signed [SW-1:0]          mul_a;
  logic signed [SW-1:0]          mul_b;
  logic signed [pel_pkg::ProdW-1:0] mul_p;
  logic [LW-1:0]                 env_step;
  logic [LW-1:0]                 env_upd;
  logic [pel_pkg::RatioW:0]      div_shl;
  logic [pel_pkg::RatioW:0]      div_sub;
  logic                          div_ge;
  logic [pel_pkg::RatioW-1:0]    div_rem;
  logic [LW-1:0]                 div_quot;
  logic signed [SW:0]            y_full;
  logic signed [SW-1:0]          y_sat;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_sample_out     = out_sample_r;
  assign out_gain_applied   = out_gain_r;
  assign out_envelope_level = out_env_r;

  // Magnitude of the incoming sample; the most negative code folds onto
  // full scale so the magnitude fits in fifteen bits.
  assign in_neg = (~in_sample_in) + 16'd1;
  always_comb begin
    if (!in_sample_in[SW-1]) begin
      in_mag = in_sample_in[LW-1:0];
    end else if (in_neg[LW-1:0] == '0) begin
      in_mag = pel_pkg::UnityQ15;
    end else begin
      in_mag = in_neg[LW-1:0];
    end
  end

  // Envelope direction and distance for the follower update.
  assign rise     = (mag_r > env_r);
  assign env_diff = rise ? (mag_r - env_r) : (env_r - mag_r);
  assign coeff    = rise ? atk_r : rel_r;

  // The one multiplier serves both the envelope smoothing product and the
  // final gain product. Its result is always registered in prod_r.
  assign mul_a = (state_r == S_OUT_MUL) ? x_r : $signed({1'b0, env_diff});
  assign mul_b = (state_r == S_OUT_MUL) ? $signed({1'b0, gain_r})
                                        : $signed({1'b0, coeff});
  assign mul_p = mul_a * mul_b;

  // The smoothing step never exceeds the distance, so fifteen bits hold it
  // and the envelope cannot wrap.
  assign env_step = prod_r[2*LW-1:LW];
  assign env_upd  = rise_r ? (env_r + env_step) : (env_r - env_step);

  // One restoring division step: shift in the next dividend bit, subtract
  // the divisor if it fits, and shift the quotient bit in at the bottom.
  assign div_shl  = {rem_r, dvd_r[DW-1]};
  assign div_sub  = div_shl - {1'b0, dvs_r};
  assign div_ge   = (div_shl >= {1'b0, dvs_r});
  assign div_rem  = div_ge ? div_sub[pel_pkg::RatioW-1:0]
                           : div_shl[pel_pkg::RatioW-1:0];
  assign div_quot = {dvd_r[LW-2:0], div_ge};

  // Floor shift of the output product, then saturation to sixteen bits.
  assign y_full = prod_r[pel_pkg::ProdW-1:LW];
  always_comb begin
    if (y_full[SW] != y_full[SW-1]) begin
      y_sat = y_full[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      y_sat = y_full[SW-1:0];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    thr_nxt        = thr_r;
    ratio_nxt      = ratio_r;
    atk_nxt        = atk_r;
    rel_nxt        = rel_r;
    env_nxt        = env_r;
    x_nxt          = x_r;
    mag_nxt        = mag_r;
    rise_nxt       = rise_r;
    prod_nxt       = prod_r;
    a_nxt          = a_r;
    gain_nxt       = gain_r;
    rem_nxt        = rem_r;
    dvd_nxt        = dvd_r;
    dvs_nxt        = dvs_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    out_gain_nxt   = out_gain_r;
    out_env_nxt    = out_env_r;

    // Configuration writes; a ratio of zero is stored as one so the second
    // division always has a nonzero divisor.
    if (cfg_wr_en) begin
      unique case (pel_pkg::cfg_reg_t'(cfg_index))
        pel_pkg::REG_THRESHOLD: thr_nxt = cfg_wdata[LW-1:0];
        pel_pkg::REG_RATIO: begin
          ratio_nxt = (cfg_wdata == '0) ? {{(pel_pkg::RatioW-1){1'b0}}, 1'b1}
                                        : cfg_wdata[pel_pkg::RatioW-1:0];
        end
        pel_pkg::REG_ATTACK:    atk_nxt = cfg_wdata[LW-1:0];
        pel_pkg::REG_RELEASE:   rel_nxt = cfg_wdata[LW-1:0];
        default: ;
      endcase
    end

    // The result register empties as soon as the consumer takes it.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          x_nxt     = in_sample_in;
          mag_nxt   = in_mag;
          state_nxt = S_ENV_MUL;
        end
      end
      S_ENV_MUL: begin
        prod_nxt  = mul_p;
        rise_nxt  = rise;
        state_nxt = S_ENV_UPD;
      end
      S_ENV_UPD: begin
        env_nxt = env_upd;
        // Gain reduction starts only above the threshold, which also keeps
        // the envelope divisor at one or more.
        if (env_upd > thr_r) begin
          rem_nxt   = '0;
          dvd_nxt   = {thr_r, {LW{1'b0}}};
          dvs_nxt   = {1'b0, env_upd};
          cnt_nxt   = pel_pkg::DivAlphaSteps;
          state_nxt = S_DIV_A;
        end else begin
          gain_nxt  = pel_pkg::UnityQ15;
          state_nxt = S_OUT_MUL;
        end
      end
      S_DIV_A: begin
        rem_nxt = div_rem;
        dvd_nxt = {dvd_r[DW-2:0], div_ge};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          // The quotient is below 2^15 because threshold < envelope. Reload
          // the divider with the headroom term over the ratio.
          a_nxt     = div_quot;
          rem_nxt   = '0;
          dvd_nxt   = {pel_pkg::UnityQ15 - div_quot, {LW{1'b0}}};
          dvs_nxt   = ratio_r;
          cnt_nxt   = pel_pkg::DivGainSteps;
          state_nxt = S_DIV_G;
        end
      end
      S_DIV_G: begin
        rem_nxt = div_rem;
        dvd_nxt = {dvd_r[DW-2:0], div_ge};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          // The sum cannot exceed unity since the quotient is at most the
          // headroom it was taken from.
          gain_nxt  = a_r + div_quot;
          state_nxt = S_OUT_MUL;
        end
      end
      S_OUT_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // Hold the finished result until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = y_sat;
          out_gain_nxt   = gain_r;
          out_env_nxt    = env_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= pel_pkg::ThresholdReset;
      ratio_r     <= pel_pkg::RatioReset;
      atk_r       <= pel_pkg::AttackReset;
      rel_r       <= pel_pkg::ReleaseReset;
      env_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      thr_r       <= thr_nxt;
      ratio_r     <= ratio_nxt;
      atk_r       <= atk_nxt;
      rel_r       <= rel_nxt;
      env_r       <= env_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    mag_r        <= mag_nxt;
    rise_r       <= rise_nxt;
    prod_r       <= prod_nxt;
    a_r          <= a_nxt;
    gain_r       <= gain_nxt;
    rem_r        <= rem_nxt;
    dvd_r        <= dvd_nxt;
    dvs_r        <= dvs_nxt;
    out_sample_r <= out_sample_nxt;
    out_gain_r   <= out_gain_nxt;
    out_env_r    <= out_env_nxt;
  end

  // An accepted request always starts with the envelope multiply.
  `PEL_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_r == S_ENV_MUL,
                   "accepted request did not start the envelope multiply")

  // The divider never runs with an exhausted step counter.
  `PEL_ASSERT_IMPL(a_div_count, state_r == S_DIV_A || state_r == S_DIV_G, cnt_r != '0,
                   "divider active with zero step count")

  // A reduced gain is only reported with an envelope above the threshold.
  `PEL_ASSERT_IMPL(a_gain_reduce, out_valid && out_gain_applied != pel_pkg::UnityQ15,
                   out_envelope_level > thr_r,
                   "gain reduction reported at or below the threshold")

endmodule
